### hdl/dsh_pkg.sv
package dsh_pkg;

    // Grid geometry (torus side, power of two)
    localparam int GRID_SIZE = 64;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int AW        = 2 * CW;
    localparam int SW        = CW + 1;
    localparam int DEPTH     = GRID_SIZE * GRID_SIZE;

    // Data formats
    localparam int HW      = 24;
    localparam int RW      = 16;
    localparam int CFG_W   = 8;
    localparam int FRAC_SH = 8;
    localparam int AMPW    = CFG_W + FRAC_SH;
    localparam int PRODW   = RW + AMPW + 1;
    localparam int OFFW    = PRODW - (RW - 1);
    localparam int NNB     = 4;
    localparam int ACCW    = HW + $clog2(NNB);
    localparam int PHW     = $clog2(NNB);
    localparam int POINT_W = 6;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_SEED = 1'b0;
    localparam logic [0:0] REG_AMP  = 1'b1;
    localparam logic [CFG_W-1:0] SEED_RST = 8'd64;
    localparam logic [CFG_W-1:0] AMP_RST  = 8'd40;

    typedef struct packed {
        logic [NNB-1:0][AW-1:0] nb;
        logic [CW-1:0]          px;
        logic [CW-1:0]          py;
        logic signed [OFFW-1:0] offset;
        logic [HW-1:0]          seed_h;
        logic                   seed;
        logic                   last;
    } t_desc;

endpackage

### hdl/diamond_square_heightmap_top.sv
// Diamond-square heightmap generator over a toroidal grid.
// Input channel: i_valid / o_stall carries one signed Q1.15 random fraction
// per beat. Every accepted beat fills exactly one new grid point, so a full
// generation takes GRID_SIZE*GRID_SIZE-1 beats; o_last_point marks the final
// one and the next beat reseeds cell (0,0) and starts over.
// Output channel: o_valid / i_stall carries point_x, point_y, the Q16.8 height
// and the last flag, one beat per input beat, in input order.
// APB port: register 0 (address 0) is corner_seed, register 1 (address 4) is
// initial_amplitude; both are sampled when a generation starts.
// Throughput is bounded by the four neighbor reads, one after another, on the
// single read port of the height store; the store write overlaps the next
// point's first read. A two-entry queue lets inputs keep arriving meanwhile.
// Reset (synchronous, active low) clears the scan, the queue and the output
// valid; the height store is not cleared. When the receiver stalls, the
// result holds, the back end stops after one more finished point, and
// o_stall rises once the queue fills.
module diamond_square_heightmap_top import dsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [RW-1:0]  i_rand_fraction,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [POINT_W-1:0]    o_point_x,
    output logic [POINT_W-1:0]    o_point_y,
    output logic signed [HW-1:0]  o_height,
    output logic                  o_last_point,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_corner_seed;
    logic [CFG_W-1:0] r_init_amp;
    logic [0:0]       reg_idx;
    logic             take, q_full, q_valid, pop;
    t_desc            front_desc, q_desc;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_SEED: prdata = PDATA_W'(r_corner_seed);
            REG_AMP:  prdata = PDATA_W'(r_init_amp);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_seed <= SEED_RST;
            r_init_amp    <= AMP_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_SEED: r_corner_seed <= pwdata[CFG_W-1:0];
                REG_AMP:  r_init_amp    <= pwdata[CFG_W-1:0];
                default:  ;
            endcase
        end
    end

    assign take    = i_valid && !q_full;
    assign o_stall = q_full;

    dsh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_rand_fraction (i_rand_fraction),
        .i_corner_seed   (r_corner_seed),
        .i_init_amp      (r_init_amp),
        .o_desc          (front_desc)
    );

    dsh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (front_desc),
        .i_pop   (pop),
        .o_data  (q_desc),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    dsh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_desc),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_height     (o_height),
        .o_last_point (o_last_point)
    );

endmodule

### hdl/dsh_front.sv
module dsh_front import dsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic signed [RW-1:0]  i_rand_fraction,
    input  logic [CFG_W-1:0]      i_corner_seed,
    input  logic [CFG_W-1:0]      i_init_amp,
    output t_desc                 o_desc
);

    logic [SW-1:0]   r_side, n_side;
    logic [AMPW-1:0] r_amp, n_amp;
    logic [CW-1:0]   r_col, n_col;
    logic [CW-1:0]   r_row, n_row;
    logic            r_diam, n_diam;
    logic            r_seeded, n_seeded;

    logic [SW-1:0]   side, half, row_sum, col_sum;
    logic [CW-1:0]   col, row, side_c, half_c, px, py;
    logic [AMPW-1:0] amp;
    logic            diam, last;
    logic signed [PRODW-1:0] prod;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return {y, x};
    endfunction

    always_comb begin
        // a fresh generation starts from the top pass
        if (r_seeded) begin
            side = r_side;
            amp  = r_amp;
            col  = r_col;
            row  = r_row;
            diam = r_diam;
        end else begin
            side = SW'(GRID_SIZE);
            amp  = {i_init_amp, {FRAC_SH{1'b0}}};
            col  = '0;
            row  = '0;
            diam = 1'b0;
        end
        half   = side >> 1;
        side_c = side[CW-1:0];
        half_c = half[CW-1:0];

        if (!diam) begin
            px = col + half_c;
            py = row + half_c;
            o_desc.nb[0] = cell_addr(col, row);
            o_desc.nb[1] = cell_addr(col + side_c, row);
            o_desc.nb[2] = cell_addr(col, row + side_c);
            o_desc.nb[3] = cell_addr(col + side_c, row + side_c);
        end else begin
            px = col;
            py = row;
            o_desc.nb[0] = cell_addr(col - half_c, row);
            o_desc.nb[1] = cell_addr(col + half_c, row);
            o_desc.nb[2] = cell_addr(col, row + half_c);
            o_desc.nb[3] = cell_addr(col, row - half_c);
        end

        prod = $signed(i_rand_fraction) * $signed({1'b0, amp});

        // advance the scan
        row_sum  = {1'b0, row} + side;
        col_sum  = {1'b0, col} + (diam ? half : side);
        n_side   = side;
        n_amp    = amp;
        n_col    = col;
        n_row    = row;
        n_diam   = diam;
        n_seeded = 1'b1;
        last     = 1'b0;
        if (row_sum >= SW'(GRID_SIZE)) begin
            if (col_sum >= SW'(GRID_SIZE)) begin
                n_col = '0;
                if (!diam) begin
                    n_diam = 1'b1;
                    n_row  = half_c;
                end else begin
                    n_side = side >> 1;
                    n_amp  = amp >> 1;
                    n_diam = 1'b0;
                    n_row  = '0;
                    if (n_side < SW'(2)) begin
                        last     = 1'b1;
                        n_seeded = 1'b0;
                    end
                end
            end else begin
                n_col = col_sum[CW-1:0];
                n_row = diam ? ((col_sum[CW-1:0] + half_c) & (side_c - CW'(1))) : '0;
            end
        end else begin
            n_row = row_sum[CW-1:0];
        end

        o_desc.px     = px;
        o_desc.py     = py;
        o_desc.offset = prod[PRODW-1:RW-1];
        o_desc.seed_h = HW'({i_corner_seed, {FRAC_SH{1'b0}}});
        o_desc.seed   = !r_seeded;
        o_desc.last   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side   <= SW'(GRID_SIZE);
            r_amp    <= {AMP_RST, {FRAC_SH{1'b0}}};
            r_col    <= '0;
            r_row    <= '0;
            r_diam   <= 1'b0;
            r_seeded <= 1'b0;
        end else if (i_take) begin
            r_side   <= n_side;
            r_amp    <= n_amp;
            r_col    <= n_col;
            r_row    <= n_row;
            r_diam   <= n_diam;
            r_seeded <= n_seeded;
        end
    end

endmodule

### hdl/dsh_queue.sv
module dsh_queue import dsh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_valid,
    output logic  o_full
);

    t_desc          r_mem [QDEPTH];
    logic [QPW-1:0] r_wptr, r_rptr;
    logic [QPW:0]   r_count;

    assign o_data  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QPW+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPW+1)'(1);
                2'b01:   r_count <= r_count - (QPW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/dsh_back.sv
module dsh_back import dsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_desc                 i_q_data,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [POINT_W-1:0]    o_point_x,
    output logic [POINT_W-1:0]    o_point_y,
    output logic signed [HW-1:0]  o_height,
    output logic                  o_last_point
);

    localparam logic [PHW-1:0] LAST_PHASE = PHW'(NNB - 1);
    localparam logic [PHW-1:0] SEED_PHASE = PHW'(1);

    // issue stage
    logic           r_a_valid;
    logic [PHW-1:0] r_a_phase;
    t_desc          r_a_desc;
    // read return stage
    logic           r_r_valid;
    logic [PHW-1:0] r_r_phase;
    logic           r_r_seed;
    logic [HW-1:0]  r_r_seed_h;
    t_desc          r_b_desc;
    logic signed [ACCW-1:0] r_acc;
    // height store
    logic [HW-1:0]  r_mem [DEPTH];
    logic [HW-1:0]  r_rdata;
    logic           r_fwd_hit;
    logic [HW-1:0]  r_fwd_val;
    // result register
    logic                 r_o_valid;
    logic [POINT_W-1:0]   r_o_x, r_o_y;
    logic signed [HW-1:0] r_o_h;
    logic                 r_o_last;

    logic                   fin, adv, pop, seed_we, wr_en;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [HW-1:0]          data, wr_data;
    logic signed [ACCW-1:0] data_x, sum;
    logic signed [HW:0]     h_wide;
    logic signed [HW-1:0]   h_sat;

    always_comb begin
        fin = r_r_valid && (r_r_phase == LAST_PHASE);
        // the whole back end holds while a finished point cannot leave
        adv = !(fin && r_o_valid && i_stall);
        pop = adv && i_q_valid && (!r_a_valid || (r_a_phase == LAST_PHASE));
        rd_addr = r_a_desc.nb[r_a_phase];

        // the first point of a generation sees only the seed corner
        data   = r_r_seed ? r_r_seed_h : (r_fwd_hit ? r_fwd_val : r_rdata);
        data_x = {{(ACCW-HW){data[HW-1]}}, data};
        sum    = r_acc + data_x;
        h_wide = {sum[ACCW-1], sum[ACCW-1:ACCW-HW]}
               + {{(HW+1-OFFW){r_b_desc.offset[OFFW-1]}}, r_b_desc.offset};
        if (h_wide[HW] != h_wide[HW-1]) begin
            h_sat = h_wide[HW] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
        end else begin
            h_sat = h_wide[HW-1:0];
        end

        seed_we = adv && r_a_valid && r_a_desc.seed && (r_a_phase == SEED_PHASE);
        wr_en   = (fin && adv) || seed_we;
        wr_addr = seed_we ? '0 : {r_b_desc.py, r_b_desc.px};
        wr_data = seed_we ? r_a_desc.seed_h : h_sat;
    end

    assign o_pop        = pop;
    assign o_valid      = r_o_valid;
    assign o_point_x    = r_o_x;
    assign o_point_y    = r_o_y;
    assign o_height     = r_o_h;
    assign o_last_point = r_o_last;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (wr_en) begin
                r_mem[wr_addr] <= wr_data;
            end
            r_rdata <= r_mem[rd_addr];
        end
    end

    // a write at the edge that issues a read of the same cell bypasses the store
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_hit <= wr_en && (wr_addr == rd_addr);
            r_fwd_val <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_phase <= '0;
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) begin
                if (pop) begin
                    r_a_valid <= 1'b1;
                    r_a_phase <= '0;
                end else if (r_a_valid && (r_a_phase == LAST_PHASE)) begin
                    r_a_valid <= 1'b0;
                end else if (r_a_valid) begin
                    r_a_phase <= r_a_phase + PHW'(1);
                end
                r_r_valid <= r_a_valid;
            end
            if (fin && adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r_phase  <= r_a_phase;
            r_r_seed   <= r_a_desc.seed;
            r_r_seed_h <= r_a_desc.seed_h;
            if (pop) begin
                r_a_desc <= i_q_data;
            end
            if (r_a_valid && (r_a_phase == LAST_PHASE)) begin
                r_b_desc <= r_a_desc;
            end
            if (r_r_valid) begin
                r_acc <= (r_r_phase == '0) ? data_x : sum;
            end
        end
        if (fin && adv) begin
            r_o_x    <= POINT_W'(r_b_desc.px);
            r_o_y    <= POINT_W'(r_b_desc.py);
            r_o_h    <= h_sat;
            r_o_last <= r_b_desc.last;
        end
    end

endmodule

### hdl/dsh_checker.sv
module dsh_checker import dsh_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [POINT_W-1:0]   o_point_x,
    input logic [POINT_W-1:0]   o_point_y,
    input logic signed [HW-1:0] o_height,
    input logic                 o_last_point
);

    localparam logic [POINT_W-1:0] LAST_X = POINT_W'(GRID_SIZE - 1);
    localparam logic [POINT_W-1:0] LAST_Y = POINT_W'(GRID_SIZE - 2);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_height) && $stable(o_last_point))
        else $error("stalled result changed");

    // the final diamond point of the smallest pass sits in the last column, second-to-last row
    a_last_point_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_point |-> (o_point_x == LAST_X) && (o_point_y == LAST_Y))
        else $error("last point at wrong coordinates");

    // cell (0,0) is the seed and is never emitted as a generated point
    a_no_seed_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (GRID_SIZE > (1 << POINT_W)) || (o_point_x != '0) || (o_point_y != '0))
        else $error("seed cell emitted as a point");

endmodule

bind diamond_square_heightmap_top dsh_checker u_dsh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_point_x    (o_point_x),
    .o_point_y    (o_point_y),
    .o_height     (o_height),
    .o_last_point (o_last_point)
);

### sim/diamond_square_heightmap_checker.sv
`timescale 1ns / 100ps

module diamond_square_heightmap_checker import dsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic signed [RW-1:0]  i_frac,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [POINT_W-1:0]    i_x,
    input  logic [POINT_W-1:0]    i_y,
    input  logic signed [HW-1:0]  i_height,
    input  logic                  i_last,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [PADDR_W-1:0]    i_paddr,
    input  logic [PDATA_W-1:0]    i_pwdata,
    output int                    o_errors,
    output int                    o_pending
);

    localparam longint H_TOP = 2**(HW-1) - 1;
    localparam longint H_BOT = -(2**(HW-1));

    typedef struct packed {
        logic [POINT_W-1:0]   x;
        logic [POINT_W-1:0]   y;
        logic signed [HW-1:0] h;
        logic                 last;
    } t_point;

    // Local copy of the terrain and of the scan position
    int               heights [DEPTH];
    int               span;
    int               amp_q;
    int               scan_x;
    int               scan_y;
    bit               diamond;
    bit               gen_live;
    logic [CFG_W-1:0] seed_reg;
    logic [CFG_W-1:0] amp_reg;
    t_point           points_due [$];
    int               fault_count;

    function automatic int cell_at(input int x, input int y);
        return (x % GRID_SIZE) + (y % GRID_SIZE) * GRID_SIZE;
    endfunction

    // Fill the next point of the diamond-square walk and advance the scan.
    function automatic t_point next_point(input logic signed [RW-1:0] frac);
        int     half;
        int     px;
        int     py;
        int     nb [NNB];
        longint acc;
        longint lvl;
        t_point pt;
        if (!gen_live) begin
            heights[0] = seed_reg << FRAC_SH;
            amp_q      = amp_reg << FRAC_SH;
            span       = GRID_SIZE;
            scan_x     = 0;
            scan_y     = 0;
            diamond    = 1'b0;
            gen_live   = 1'b1;
        end
        half = span / 2;
        if (!diamond) begin
            px    = scan_x + half;
            py    = scan_y + half;
            nb[0] = cell_at(scan_x, scan_y);
            nb[1] = cell_at(scan_x + span, scan_y);
            nb[2] = cell_at(scan_x, scan_y + span);
            nb[3] = cell_at(scan_x + span, scan_y + span);
        end else begin
            px    = scan_x;
            py    = scan_y;
            nb[0] = cell_at(px + GRID_SIZE - half, py);
            nb[1] = cell_at(px + half, py);
            nb[2] = cell_at(px, py + half);
            nb[3] = cell_at(px, py + GRID_SIZE - half);
        end
        acc = 0;
        foreach (nb[k])
            acc += heights[nb[k]];
        // arithmetic shifts floor toward minus infinity
        lvl = (acc >>> 2) + ((longint'(frac) * longint'(amp_q)) >>> (RW - 1));
        if (lvl > H_TOP)
            lvl = H_TOP;
        if (lvl < H_BOT)
            lvl = H_BOT;
        heights[cell_at(px, py)] = int'(lvl);

        pt.x    = px[POINT_W-1:0];
        pt.y    = py[POINT_W-1:0];
        pt.h    = lvl[HW-1:0];
        pt.last = 1'b0;

        scan_y += span;
        if (scan_y >= GRID_SIZE) begin
            if (!diamond) begin
                scan_y = 0;
                scan_x += span;
                if (scan_x >= GRID_SIZE) begin
                    diamond = 1'b1;
                    scan_x  = 0;
                    scan_y  = half % span;
                end
            end else begin
                scan_x += half;
                if (scan_x >= GRID_SIZE) begin
                    span    = span / 2;
                    amp_q   = amp_q >> 1;
                    diamond = 1'b0;
                    scan_x  = 0;
                    scan_y  = 0;
                    if (span < 2) begin
                        pt.last  = 1'b1;
                        gen_live = 1'b0;
                    end
                end else begin
                    scan_y = (scan_x + half) % span;
                end
            end
        end
        return pt;
    endfunction

    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (!i_rst_n) begin
            seed_reg = SEED_RST;
            amp_reg  = AMP_RST;
            span     = GRID_SIZE;
            amp_q    = AMP_RST << FRAC_SH;
            scan_x   = 0;
            scan_y   = 0;
            diamond  = 1'b0;
            gen_live = 1'b0;
            points_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_SEED: seed_reg = i_pwdata[CFG_W-1:0];
                    REG_AMP:  amp_reg  = i_pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                points_due.push_back(next_point(i_frac));
            if (i_out_valid && !i_out_stall) begin
                got = {i_x, i_y, i_height, i_last};
                if (points_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 100)
                        $display("%0t: extra beat, expected none, got x=%0d y=%0d h=%0d l=%0b",
                                 $time, got.x, got.y, got.h, got.last);
                end else begin
                    want = points_due.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= 100)
                            $display(
                                "%0t: exp x=%0d y=%0d h=%0d l=%0b, got x=%0d y=%0d h=%0d l=%0b",
                                $time, want.x, want.y, want.h, want.last,
                                got.x, got.y, got.h, got.last);
                    end
                end
            end
        end
        o_errors  <= fault_count;
        o_pending <= points_due.size();
    end

endmodule

### sim/diamond_square_heightmap_top_tb.sv
`timescale 1ns / 100ps

module diamond_square_heightmap_top_tb import dsh_pkg::*; ();

    typedef enum int {PACE_NONE, PACE_LIGHT, PACE_FULL} t_pace;

    typedef struct {
        logic [CFG_W-1:0] seed;
        logic [CFG_W-1:0] amp;
        int               beats;
    } t_phase;

    localparam int PAD_W = PDATA_W - CFG_W;
    localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'({REG_SEED, 2'b00});
    localparam logic [PADDR_W-1:0] AMP_ADDR  = PADDR_W'({REG_AMP, 2'b00});

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic signed [RW-1:0]  i_rand_fraction;
    logic                  o_valid;
    logic                  i_stall;
    logic [POINT_W-1:0]    o_point_x;
    logic [POINT_W-1:0]    o_point_y;
    logic signed [HW-1:0]  o_height;
    logic                  o_last_point;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int error_count;
    int pending;

    diamond_square_heightmap_top DUT (.*);

    diamond_square_heightmap_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_frac      (i_rand_fraction),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_x         (o_point_x),
        .i_y         (o_point_y),
        .i_height    (o_height),
        .i_last      (o_last_point),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (error_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_wait(input t_pace pace);
        case (pace)
            PACE_NONE:  return 0;
            PACE_LIGHT: return $urandom_range(0, 3);
            default:    return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic logic [RW-1:0] pick_frac();
        logic [RW-1:0] corners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 3)];
        return RW'($urandom);
    endfunction

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {PAD_W'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the beat until the block takes it.
    task automatic send_beat(input logic [RW-1:0] frac, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_rand_fraction <= frac;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        int    hold;
        int    taken;
        t_pace take_pace;
        taken     = 0;
        take_pace = PACE_NONE;
        forever begin
            if (taken % 64 == 0)
                take_pace = t_pace'($urandom_range(0, 2));
            hold = pick_wait(take_pace);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin
        t_phase        plan [4];
        logic [RW-1:0] opening [12];
        t_pace         send_pace;
        logic [RW-1:0] frac;
        opening = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000,
                    16'hC000, 16'h5555, 16'hAAAA, 16'h8001, 16'h7FFE, 16'hFFFE};
        // settings after the first land mid-generation and must not take effect
        plan[0] = '{8'hFF, 8'hFF, 700};
        plan[1] = '{8'h00, 8'hFF, 500};
        plan[2] = '{CFG_W'($urandom), CFG_W'($urandom), 740};
        plan[3] = '{8'h00, 8'h00, 60};
        send_pace = PACE_NONE;

        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_rand_fraction <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 4; p++) begin
            reg_write(SEED_ADDR, plan[p].seed);
            reg_write(AMP_ADDR, plan[p].amp);
            for (int n = 0; n < plan[p].beats; n++) begin
                if (n % 64 == 0)
                    send_pace = t_pace'($urandom_range(0, 2));
                if (p == 0 && n < 12)
                    frac = opening[n];
                else
                    frac = pick_frac();
                send_beat(frac, pick_wait(send_pace));
            end
            i_valid <= 1'b0;
            // drain before touching the registers again
            do @(posedge i_clk); while (pending != 0);
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("diamond_square_heightmap_top_tb: clean");
        else
            $display("diamond_square_heightmap_top_tb: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("diamond_square_heightmap_top_tb: errors");
        $finish;
    end

endmodule
